// File: src/itda_pkg.sv
package itda_pkg;

    // Register and character widths
    localparam int MIN_WIDTH_W = 7;
    localparam int CHAR_W      = 8;

    // Characters the block emits
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Program steps
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SETUP,
        S_PAD,
        S_SIGN,
        S_DIGIT
    } t_step;

    // Datapath actions, one per control word
    typedef enum logic [2:0] {
        A_LOAD,
        A_SHIFT,
        A_SETUP,
        A_SPACE,
        A_MINUS,
        A_DIGIT
    } t_act;

    // Skip conditions: when true the action is dropped and the step jumps
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_BITS_DONE,
        C_PAD_DONE,
        C_POSITIVE,
        C_DIGITS_DONE
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_cword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic no_in;
        logic bits_done;
        logic pad_done;
        logic positive;
        logic digits_done;
        logic slot_free;
    } t_flags;

    // Control from the sequencer to the datapath
    typedef struct packed {
        t_act act;
        logic fire;
        logic idle;
    } t_ctrl;

endpackage

// File: src/itda_seq.sv
module itda_seq
    import itda_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_cword w_cw;
    logic   w_skip;
    logic   w_emit;
    logic   w_stall;

    // Control store: one word per step
    function automatic t_cword rom(input t_step s);
        t_cword w;
        case (s)
            S_IDLE:  w = '{act: A_LOAD,  cond: C_NO_IN,       jmp: S_IDLE,  nxt: S_CONV};
            S_CONV:  w = '{act: A_SHIFT, cond: C_BITS_DONE,   jmp: S_SETUP, nxt: S_CONV};
            S_SETUP: w = '{act: A_SETUP, cond: C_NEVER,       jmp: S_PAD,   nxt: S_PAD};
            S_PAD:   w = '{act: A_SPACE, cond: C_PAD_DONE,    jmp: S_SIGN,  nxt: S_PAD};
            S_SIGN:  w = '{act: A_MINUS, cond: C_POSITIVE,    jmp: S_DIGIT, nxt: S_DIGIT};
            S_DIGIT: w = '{act: A_DIGIT, cond: C_DIGITS_DONE, jmp: S_IDLE,  nxt: S_DIGIT};
            default: w = '{act: A_SETUP, cond: C_ALWAYS,      jmp: S_IDLE,  nxt: S_IDLE};
        endcase
        return w;
    endfunction

    // Decode the current word and pick the next step
    always_comb begin
        w_cw = rom(r_step);
        case (w_cw.cond)
            C_NEVER:       w_skip = 1'b0;
            C_ALWAYS:      w_skip = 1'b1;
            C_NO_IN:       w_skip = i_flags.no_in;
            C_BITS_DONE:   w_skip = i_flags.bits_done;
            C_PAD_DONE:    w_skip = i_flags.pad_done;
            C_POSITIVE:    w_skip = i_flags.positive;
            C_DIGITS_DONE: w_skip = i_flags.digits_done;
            default:       w_skip = 1'b1;
        endcase
        w_emit  = (w_cw.act == A_SPACE) || (w_cw.act == A_MINUS) || (w_cw.act == A_DIGIT);
        // hold an emitting step while the output register is occupied
        w_stall = !w_skip && w_emit && !i_flags.slot_free;
        if (w_skip) begin
            n_step = w_cw.jmp;
        end else if (w_stall) begin
            n_step = r_step;
        end else begin
            n_step = w_cw.nxt;
        end
        o_ctrl.act  = w_cw.act;
        o_ctrl.fire = !w_skip && !w_stall;
        o_ctrl.idle = (r_step == S_IDLE);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: src/int_to_decimal_ascii_padded.sv
// Signed integer to right-aligned decimal ASCII text.
//
// Input channel (i_valid / o_ready, i_value) takes one signed number. The
// output channel (o_valid / i_ready) returns its text one character per item,
// most significant first: leading spaces up to the configured minimum width,
// a '-' for negative values, then the digits. o_last marks the final digit.
// i_cfg_we / i_cfg_data write the minimum width; widths above OUTPUT_LIMIT
// are clamped. Write it only while the block is idle.
//
// A small microcode sequencer steps a binary-to-BCD shift datapath.
// Conversion shifts in one magnitude bit per cycle, then a setup step
// counts the digits and the padding; the text then follows one character
// at a time, each held in the output register until the receiver takes it.
// One item is worked on at a time; o_ready is high only between items.
// A stalled receiver freezes the sequencer on its current character;
// nothing is dropped. Synchronous reset returns to idle, clears the width to
// zero and empties the output register.
module int_to_decimal_ascii_padded
    import itda_pkg::*;
#(
    parameter int OUTPUT_LIMIT = 64,
    parameter int VALUE_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_BITS-1:0]  i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CHAR_W-1:0]      o_char_out,
    output logic                   o_last,
    input  logic                   i_cfg_we,
    input  logic [MIN_WIDTH_W-1:0] i_cfg_data
);

    // Decimal digits of the largest magnitude 2^(VALUE_BITS-1)
    localparam int DIGIT_DEPTH = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int DI_W        = $clog2(DIGIT_DEPTH);
    localparam int DC_W        = $clog2(DIGIT_DEPTH + 1);
    localparam int BC_W        = $clog2(VALUE_BITS + 1);
    localparam int LIM_W       = $clog2(OUTPUT_LIMIT + 1);
    localparam int CMP_W       = (LIM_W > MIN_WIDTH_W) ? LIM_W : MIN_WIDTH_W;

    t_flags w_flags;
    t_ctrl  w_ctrl;

    logic [MIN_WIDTH_W-1:0] r_min_width;
    logic [VALUE_BITS-1:0]  r_mag;
    logic                   r_neg;
    logic [BC_W-1:0]        r_bits;
    logic [3:0]             r_digit [DIGIT_DEPTH];
    logic [DC_W-1:0]        r_dcnt;
    logic [LIM_W-1:0]       r_pad;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic [3:0]             w_adj [DIGIT_DEPTH];
    logic [3:0]             w_sh  [DIGIT_DEPTH];
    logic [DIGIT_DEPTH:0]   w_nz;
    logic [VALUE_BITS-1:0]  w_load_mag;
    logic [DC_W-1:0]        w_dcnt_eff;
    logic [CMP_W-1:0]       w_text_len;
    logic [CMP_W-1:0]       w_width;
    logic [CMP_W-1:0]       w_pad;
    logic [DI_W-1:0]        w_idx;
    logic                   w_emit;
    logic [CHAR_W-1:0]      w_char;

    itda_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // Status for the sequencer
    always_comb begin
        w_flags.no_in       = !i_valid;
        w_flags.bits_done   = (r_bits == '0);
        w_flags.pad_done    = (r_pad == '0);
        w_flags.positive    = !r_neg;
        w_flags.digits_done = (r_dcnt == '0);
        w_flags.slot_free   = !r_out_valid || i_ready;
    end

    // Shift-and-add-3 step over the BCD digits
    always_comb begin
        for (int i = 0; i < DIGIT_DEPTH; i++) begin
            w_adj[i] = (r_digit[i] >= 4'd5) ? r_digit[i] + 4'd3 : r_digit[i];
        end
        w_sh[0] = {w_adj[0][2:0], r_mag[VALUE_BITS-1]};
        for (int i = 1; i < DIGIT_DEPTH; i++) begin
            w_sh[i] = {w_adj[i][2:0], w_adj[i-1][3]};
        end
        for (int i = 0; i < DIGIT_DEPTH; i++) begin
            w_nz[i] = (w_sh[i] != 4'd0);
        end
        w_nz[DIGIT_DEPTH] = 1'b0;
    end

    // Magnitude, text length and padding
    always_comb begin
        w_load_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
        w_dcnt_eff = (r_dcnt == '0) ? DC_W'(1) : r_dcnt;
        w_text_len = CMP_W'(w_dcnt_eff) + CMP_W'(r_neg);
        w_width    = (CMP_W'(r_min_width) > CMP_W'(OUTPUT_LIMIT)) ?
                     CMP_W'(OUTPUT_LIMIT) : CMP_W'(r_min_width);
        w_pad      = (w_width > w_text_len) ? w_width - w_text_len : '0;
    end

    // Character selection
    always_comb begin
        w_idx  = DI_W'(r_dcnt - DC_W'(1));
        w_emit = w_ctrl.fire &&
                 ((w_ctrl.act == A_SPACE) || (w_ctrl.act == A_MINUS) ||
                  (w_ctrl.act == A_DIGIT));
        case (w_ctrl.act)
            A_SPACE: w_char = CH_SPACE;
            A_MINUS: w_char = CH_MINUS;
            default: w_char = CH_ZERO + {4'd0, r_digit[w_idx]};
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= '0;
        end else if (i_cfg_we) begin
            r_min_width <= i_cfg_data;
        end
    end

    // Datapath: load, convert, count down the text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg  <= 1'b0;
            r_dcnt <= '0;
            r_pad  <= '0;
            r_bits <= '0;
        end else if (w_ctrl.fire) begin
            case (w_ctrl.act)
                A_LOAD: begin
                    r_neg  <= i_value[VALUE_BITS-1];
                    r_mag  <= w_load_mag;
                    r_bits <= BC_W'(VALUE_BITS);
                    r_dcnt <= '0;
                    for (int i = 0; i < DIGIT_DEPTH; i++) begin
                        r_digit[i] <= 4'd0;
                    end
                end
                A_SHIFT: begin
                    r_mag  <= r_mag << 1;
                    r_bits <= r_bits - BC_W'(1);
                    r_dcnt <= r_dcnt + DC_W'(w_nz[r_dcnt]);
                    for (int i = 0; i < DIGIT_DEPTH; i++) begin
                        r_digit[i] <= w_sh[i];
                    end
                end
                A_SETUP: begin
                    r_dcnt <= w_dcnt_eff;
                    r_pad  <= w_pad[LIM_W-1:0];
                end
                A_SPACE: begin
                    r_pad <= r_pad - LIM_W'(1);
                end
                A_DIGIT: begin
                    r_dcnt <= r_dcnt - DC_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: take a new character or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_char <= w_char;
            r_last <= (w_ctrl.act == A_DIGIT) && (r_dcnt == DC_W'(1));
        end
    end

    assign o_ready    = w_ctrl.idle;
    assign o_valid    = r_out_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DC_W'(DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_char_out >= CH_ZERO && o_char_out <= CH_ZERO + 8'd9))
        else $error("final character is not a digit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an item was taken");

    a_no_emit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.idle |-> !w_emit)
        else $error("character emitted while idle");
`endif

endmodule
